>>> design/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold on every clock edge outside reset
`define KBP_ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// implication checked on every clock edge outside reset
`define KBP_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> cons) else $error(msg);

`endif

>>> design/kbp_pkg.sv
package kbp_pkg;

    localparam int MAX_ORDER = 8;
    localparam int BITS = 8;
    localparam int RES_W = 24;
    localparam int LATENCY = 8;

    typedef logic [3:0] factor_t;
    typedef logic [RES_W-1:0] res_t;

    function automatic logic [1:0] v3(input factor_t f);
        unique case (f)
            4'd3, 4'd6, 4'd15: v3 = 2'd1;
            4'd9:              v3 = 2'd2;
            default:           v3 = 2'd0;
        endcase
    endfunction

    function automatic logic v5(input factor_t f);
        v5 = (f == 4'd5) || (f == 4'd15);
    endfunction

    function automatic logic [1:0] v2(input factor_t f);
        unique case (f)
            4'd2, 4'd6: v2 = 2'd1;
            4'd4:       v2 = 2'd2;
            4'd8:       v2 = 2'd3;
            default:    v2 = 2'd0;
        endcase
    endfunction

    function automatic res_t pow3(input logic [4:0] e);
        unique case (e)
            5'd0:  pow3 = 24'd1;
            5'd1:  pow3 = 24'd3;
            5'd2:  pow3 = 24'd9;
            5'd3:  pow3 = 24'd27;
            5'd4:  pow3 = 24'd81;
            5'd5:  pow3 = 24'd243;
            5'd6:  pow3 = 24'd729;
            5'd7:  pow3 = 24'd2187;
            5'd8:  pow3 = 24'd6561;
            5'd9:  pow3 = 24'd19683;
            5'd10: pow3 = 24'd59049;
            5'd11: pow3 = 24'd177147;
            5'd12: pow3 = 24'd531441;
            5'd13: pow3 = 24'd1594323;
            5'd14: pow3 = 24'd4782969;
            5'd15: pow3 = 24'd14348907;
            default: pow3 = 24'd0;
        endcase
    endfunction

    function automatic res_t pow5(input logic [3:0] e);
        unique case (e)
            4'd0:  pow5 = 24'd1;
            4'd1:  pow5 = 24'd5;
            4'd2:  pow5 = 24'd25;
            4'd3:  pow5 = 24'd125;
            4'd4:  pow5 = 24'd625;
            4'd5:  pow5 = 24'd3125;
            4'd6:  pow5 = 24'd15625;
            4'd7:  pow5 = 24'd78125;
            4'd8:  pow5 = 24'd390625;
            4'd9:  pow5 = 24'd1953125;
            4'd10: pow5 = 24'd9765625;
            default: pow5 = 24'd0;
        endcase
    endfunction

    function automatic res_t pow7(input logic [3:0] e);
        unique case (e)
            4'd0: pow7 = 24'd1;
            4'd1: pow7 = 24'd7;
            4'd2: pow7 = 24'd49;
            4'd3: pow7 = 24'd343;
            4'd4: pow7 = 24'd2401;
            4'd5: pow7 = 24'd16807;
            4'd6: pow7 = 24'd117649;
            4'd7: pow7 = 24'd823543;
            4'd8: pow7 = 24'd5764801;
            default: pow7 = 24'd0;
        endcase
    endfunction

    function automatic res_t pow11(input logic [3:0] e);
        unique case (e)
            4'd0: pow11 = 24'd1;
            4'd1: pow11 = 24'd11;
            4'd2: pow11 = 24'd121;
            4'd3: pow11 = 24'd1331;
            4'd4: pow11 = 24'd14641;
            4'd5: pow11 = 24'd161051;
            4'd6: pow11 = 24'd1771561;
            default: pow11 = 24'd0;
        endcase
    endfunction

    function automatic res_t pow13(input logic [3:0] e);
        unique case (e)
            4'd0: pow13 = 24'd1;
            4'd1: pow13 = 24'd13;
            4'd2: pow13 = 24'd169;
            4'd3: pow13 = 24'd2197;
            4'd4: pow13 = 24'd28561;
            4'd5: pow13 = 24'd371293;
            4'd6: pow13 = 24'd4826809;
            default: pow13 = 24'd0;
        endcase
    endfunction

endpackage

>>> design/kt_byte_probability_top.sv
// channel    | signals                                  | handshake
// command    | start, busy, data_byte                   | taken when start && !busy
// config     | cfg_we, cfg_wdata                        | written when cfg_we
// result     | done, prob_numerator, prob_denominator   | one cycle, marked by done
// a transaction enters every cycle; busy stays low
// result appears once its command has passed the eight register stages
// (input, context counts, prime exponents, cancelling, power lookup, three products with shift)
// rst_n clears the order register to 3 and all stage valid bits
// the receiver cannot stall, so no stage ever holds
module kt_byte_probability_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [7:0]  data_byte,
    input  logic        cfg_we,
    input  logic [3:0]  cfg_wdata,
    output logic        done,
    output logic [23:0] prob_numerator,
    output logic [23:0] prob_denominator
);

    logic [3:0] order_reg;
    logic [kbp_pkg::LATENCY-1:0] vld_reg;

    logic [7:0] byte1_reg;
    logic [7:0] mask1_reg;
    logic [8:0] mask_full;
    logic [3:0] order_sat;

    kbp_pkg::factor_t n2_reg [kbp_pkg::BITS];
    kbp_pkg::factor_t d2_reg [kbp_pkg::BITS];
    kbp_pkg::factor_t n2_next [kbp_pkg::BITS];
    kbp_pkg::factor_t d2_next [kbp_pkg::BITS];

    logic [4:0] e3n_reg, e3d_reg, e3n_next, e3d_next;
    logic [3:0] e5n_reg, e5d_reg, e7n_reg, e7d_reg, e11_reg, e13_reg;
    logic [3:0] e5n_next, e5d_next, e7n_next, e7d_next, e11_next, e13_next;
    logic [5:0] e2_reg, e2_next;

    logic [4:0] a3n_reg, a3d_reg, m3;
    logic [3:0] a5n_reg, a5d_reg, a7n_reg, a7d_reg, a11_reg, a13_reg, m5, m7;
    logic [5:0] a2_reg;

    kbp_pkg::res_t p3n_reg, p5n_reg, p7n_reg, p11_reg, p13_reg;
    kbp_pkg::res_t p3d_reg, p5d_reg, p7d_reg;
    logic [5:0] s2_5_reg, s2_6_reg, s2_7_reg;
    kbp_pkg::res_t q35n_reg, q711_reg, q13a_reg, q35d_reg, q7d_reg;
    kbp_pkg::res_t rn_reg, r13_reg, rd_reg;
    kbp_pkg::res_t num_reg, den_reg;

    assign busy = 1'b0;
    assign order_sat = (order_reg > 4'(kbp_pkg::MAX_ORDER)) ? 4'(kbp_pkg::MAX_ORDER) : order_reg;
    assign mask_full = (9'd1 << order_sat) - 9'd1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            order_reg <= 4'd3;
            vld_reg   <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                order_reg <= cfg_wdata;
            end
            vld_reg <= {vld_reg[kbp_pkg::LATENCY-2:0], start};
        end
    end

    // context counts per bit position
    always_comb
    begin
        logic [7:0] ctx [kbp_pkg::BITS];
        logic [2:0] z, u;
        for (int j = 0; j < kbp_pkg::BITS; j++)
        begin
            ctx[j] = (byte1_reg >> (kbp_pkg::BITS - j)) & mask1_reg;
        end
        for (int i = 0; i < kbp_pkg::BITS; i++)
        begin
            z = 3'd0;
            u = 3'd0;
            for (int j = 0; j < kbp_pkg::BITS; j++)
            begin
                if (j < i && ctx[j] == ctx[i])
                begin
                    if (byte1_reg[kbp_pkg::BITS-1-j])
                        u = u + 3'd1;
                    else
                        z = z + 3'd1;
                end
            end
            n2_next[i] = byte1_reg[kbp_pkg::BITS-1-i] ? {u, 1'b1} : {z, 1'b1};
            d2_next[i] = {1'b0, z} + {1'b0, u} + 4'd1;
        end
    end

    // prime exponents of both products
    always_comb
    begin
        e3n_next = '0; e3d_next = '0; e5n_next = '0; e5d_next = '0;
        e7n_next = '0; e7d_next = '0; e11_next = '0; e13_next = '0;
        e2_next  = 6'(kbp_pkg::BITS);
        for (int i = 0; i < kbp_pkg::BITS; i++)
        begin
            e3n_next = e3n_next + 5'(kbp_pkg::v3(n2_reg[i]));
            e5n_next = e5n_next + 4'(kbp_pkg::v5(n2_reg[i]));
            e7n_next = e7n_next + 4'(n2_reg[i] == 4'd7);
            e11_next = e11_next + 4'(n2_reg[i] == 4'd11);
            e13_next = e13_next + 4'(n2_reg[i] == 4'd13);
            e2_next  = e2_next + 6'(kbp_pkg::v2(d2_reg[i]));
            e3d_next = e3d_next + 5'(kbp_pkg::v3(d2_reg[i]));
            e5d_next = e5d_next + 4'(kbp_pkg::v5(d2_reg[i]));
            e7d_next = e7d_next + 4'(d2_reg[i] == 4'd7);
        end
    end

    assign m3 = (e3n_reg < e3d_reg) ? e3n_reg : e3d_reg;
    assign m5 = (e5n_reg < e5d_reg) ? e5n_reg : e5d_reg;
    assign m7 = (e7n_reg < e7d_reg) ? e7n_reg : e7d_reg;

    always_ff @(posedge clk)
    begin
        byte1_reg <= data_byte;
        mask1_reg <= mask_full[7:0];

        n2_reg <= n2_next;
        d2_reg <= d2_next;

        e3n_reg <= e3n_next; e3d_reg <= e3d_next;
        e5n_reg <= e5n_next; e5d_reg <= e5d_next;
        e7n_reg <= e7n_next; e7d_reg <= e7d_next;
        e11_reg <= e11_next; e13_reg <= e13_next; e2_reg <= e2_next;

        // cancel common factors
        a3n_reg <= e3n_reg - m3; a3d_reg <= e3d_reg - m3;
        a5n_reg <= e5n_reg - m5; a5d_reg <= e5d_reg - m5;
        a7n_reg <= e7n_reg - m7; a7d_reg <= e7d_reg - m7;
        a11_reg <= e11_reg; a13_reg <= e13_reg; a2_reg <= e2_reg;

        p3n_reg <= kbp_pkg::pow3(a3n_reg);
        p5n_reg <= kbp_pkg::pow5(a5n_reg);
        p7n_reg <= kbp_pkg::pow7(a7n_reg);
        p11_reg <= kbp_pkg::pow11(a11_reg);
        p13_reg <= kbp_pkg::pow13(a13_reg);
        p3d_reg <= kbp_pkg::pow3(a3d_reg);
        p5d_reg <= kbp_pkg::pow5(a5d_reg);
        p7d_reg <= kbp_pkg::pow7(a7d_reg);
        s2_5_reg <= a2_reg;

        q35n_reg <= kbp_pkg::RES_W'(p3n_reg * p5n_reg);
        q711_reg <= kbp_pkg::RES_W'(p7n_reg * p11_reg);
        q13a_reg <= p13_reg;
        q35d_reg <= kbp_pkg::RES_W'(p3d_reg * p5d_reg);
        q7d_reg  <= p7d_reg;
        s2_6_reg <= s2_5_reg;

        rn_reg   <= kbp_pkg::RES_W'(q35n_reg * q711_reg);
        r13_reg  <= q13a_reg;
        rd_reg   <= kbp_pkg::RES_W'(q35d_reg * q7d_reg);
        s2_7_reg <= s2_6_reg;

        num_reg <= kbp_pkg::RES_W'(rn_reg * r13_reg);
        den_reg <= rd_reg << s2_7_reg;
    end

    assign done             = vld_reg[kbp_pkg::LATENCY-1];
    assign prob_numerator   = num_reg;
    assign prob_denominator = den_reg;

endmodule

>>> design/kbp_checker.sv
`include "assert_macros.svh"

module kbp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        done,
    input logic [23:0] prob_numerator,
    input logic [23:0] prob_denominator
);

    `KBP_ASSERT_ALWAYS(a_never_busy, clk, rst_n, !busy, "busy raised")
    `KBP_ASSERT_IMPLIES(a_result_follows, clk, rst_n, start && !busy, ##8 done, "transaction lost")
    `KBP_ASSERT_IMPLIES(a_no_spurious, clk, rst_n, done, $past(start, 8), "result without transaction")
    `KBP_ASSERT_IMPLIES(a_nonzero, clk, rst_n, done, prob_numerator != 24'd0 && prob_denominator != 24'd0, "zero term in fraction")

endmodule

bind kt_byte_probability_top kbp_checker u_kbp_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .done             (done),
    .prob_numerator   (prob_numerator),
    .prob_denominator (prob_denominator)
);

>>> tb/sv/testbench.sv
module testbench;

    localparam int CYCLE_LIMIT = 200000;

    class prob_board;
        logic [23:0] num_q[$];
        logic [23:0] den_q[$];
        int errors;
        logic [3:0] order;

        function new();
            errors = 0;
            order = 4'd3;
        endfunction

        function void note_byte(logic [7:0] b);
            int zc[256];
            int oc[256];
            int ctx;
            int ord;
            int msk;
            int z;
            int u;
            longint n;
            longint d;
            longint x;
            longint y;
            longint r;
            ord = (order > kbp_pkg::MAX_ORDER) ? kbp_pkg::MAX_ORDER : order;
            msk = (1 << ord) - 1;
            ctx = 0;
            n = 1;
            d = 1;
            foreach (zc[k])
            begin
                zc[k] = 0;
                oc[k] = 0;
            end
            for (int i = 7; i >= 0; i--)
            begin
                z = zc[ctx];
                u = oc[ctx];
                d = d * 2 * (z + u + 1);
                if (b[i])
                begin
                    n = n * (2 * u + 1);
                    oc[ctx]++;
                    ctx = ((ctx << 1) | 1) & msk;
                end
                else
                begin
                    n = n * (2 * z + 1);
                    zc[ctx]++;
                    ctx = (ctx << 1) & msk;
                end
            end
            x = n;
            y = d;
            while (y != 0)
            begin
                r = x % y;
                x = y;
                y = r;
            end
            num_q.push_back(24'(n / x));
            den_q.push_back(24'(d / x));
        endfunction

        function void check_result(logic [23:0] n, logic [23:0] d);
            logic [23:0] en;
            logic [23:0] ed;
            if (num_q.size() == 0)
            begin
                $error("unexpected result transaction");
                errors++;
                return;
            end
            en = num_q.pop_front();
            ed = den_q.pop_front();
            if (n !== en)
            begin
                $error("prob_numerator expected %0d actual %0d", en, n);
                errors++;
            end
            if (d !== ed)
            begin
                $error("prob_denominator expected %0d actual %0d", ed, d);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    logic [7:0] data_byte;
    logic cfg_we;
    logic [3:0] cfg_wdata;
    logic done;
    logic [23:0] prob_numerator;
    logic [23:0] prob_denominator;
    int cycles;
    int idle_pct;
    prob_board board;

    kt_byte_probability_top dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .data_byte(data_byte),
        .cfg_we(cfg_we),
        .cfg_wdata(cfg_wdata),
        .done(done),
        .prob_numerator(prob_numerator),
        .prob_denominator(prob_denominator)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (rst_n && done)
            board.check_result(prob_numerator, prob_denominator);
        if (cycles > CYCLE_LIMIT)
        begin
            $display("kt_byte_probability_top test failed");
            $finish;
        end
    end

    // holds start across back-to-back transactions, dropping it only while the idle_pct draw inserts an idle gap
    task automatic send_byte(logic [7:0] b);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        start <= 1'b1;
        data_byte <= b;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        board.note_byte(b);
        @(negedge clk);
    endtask

    task automatic drain();
        start <= 1'b0;
        while (board.num_q.size() != 0)
            @(negedge clk);
        repeat (kbp_pkg::LATENCY + 4) @(negedge clk);
    endtask

    task automatic set_order(logic [3:0] v);
        drain();
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(negedge clk);
        cfg_we <= 1'b0;
        board.order = v;
    endtask

    initial
    begin
        logic [7:0] directed[$];
        logic [7:0] b;
        board = new();
        cycles = 0;
        idle_pct = 0;
        rst_n = 1'b0;
        start = 1'b0;
        data_byte = 8'd0;
        cfg_we = 1'b0;
        cfg_wdata = 4'd0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        directed = {8'h00, 8'hFF, 8'h80, 8'h01, 8'hAA, 8'h55, 8'h0F, 8'hF0, 8'h7F, 8'hFE};
        foreach (directed[i])
            send_byte(directed[i]);
        for (int o = 0; o < 16; o += 5)
        begin
            set_order(4'(o == 15 ? 15 : o));
            foreach (directed[i])
                send_byte(directed[i]);
        end
        set_order(4'd8);
        foreach (directed[i])
            send_byte(directed[i]);
        for (int ph = 0; ph < 3; ph++)
        begin
            idle_pct = (ph == 0) ? 36 : (ph == 1) ? 59 : 0;
            for (int k = 0; k < 200; k++)
            begin
                if (k % 50 == 0)
                    set_order(4'($urandom_range(15)));
                if (k == 120)
                    drain();
                b = 8'($urandom);
                send_byte(b);
            end
        end
        drain();
        if (board.errors == 0 && board.num_q.size() == 0)
            $display("kt_byte_probability_top test passed");
        else
            $display("kt_byte_probability_top test failed");
        $finish;
    end

endmodule
